### sv/particle_integrator_euler_rk4_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the particle integrator core
// Property checks in simulation; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_INTEGRATOR_EULER_RK4_CORE_MACROS_SVH
`define PARTICLE_INTEGRATOR_EULER_RK4_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define PIE_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pie check failed");
// next-cycle implication, sampled on clk, off during reset
`define PIE_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pie check failed");
`else
`define PIE_ASSERT_IMP(label, pre, post)
`define PIE_ASSERT_NXT(label, pre, post)
`endif
`endif

### sv/pie_pkg.sv
// ----------------------------------------------------------------------------
// pie_pkg
// Shared types, codes and fixed-point helpers of the particle integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package pie_pkg;

    localparam int STAGES = 4;
    localparam int SLOT_W = 2;
    localparam int DATA_W = 32;
    localparam int T_W    = 31;
    localparam int DAMP_W = 17;

    localparam logic [31:0] INV_MASS_RST = 32'd65536;
    localparam logic [16:0] DAMPING_RST  = 17'd64881;

    // configuration register indexes
    localparam logic CFG_INV_MASS = 1'b0;
    localparam logic CFG_DAMPING  = 1'b1;

    typedef enum logic [2:0] {
        FN_FORCE    = 3'd0,
        FN_EXPLICIT = 3'd1,
        FN_SEMI     = 3'd2,
        FN_STAGE    = 3'd3,
        FN_COMBINE  = 3'd4,
        FN_CLEAR    = 3'd5,
        FN_LOAD_POS = 3'd6,
        FN_LOAD_VEL = 3'd7
    } func_t;

    // command from the top level to every axis lane
    typedef struct packed {
        logic              start;
        func_t             func;
        logic [SLOT_W-1:0] slot;
        logic [T_W-1:0]    t;
    } lane_cmd_t;

    // saturating 32-bit add
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sd2147483647)
            return 32'sh7fffffff;
        else if (s < -33'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

    // Q16.16 product back to Q16.16: round half up, then saturate
    function automatic logic signed [31:0] fix_round(input logic signed [65:0] p);
        logic signed [65:0] r;
        r = (p + 66'sd32768) >>> 16;
        if (r > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (r < -66'sd2147483648)
            return 32'sh80000000;
        else
            return r[31:0];
    endfunction

endpackage

`default_nettype wire

### sv/pie_div6.sv
// ----------------------------------------------------------------------------
// pie_div6
// Weighted-sum mean: floor((w + 3) / 6) by reciprocal multiplication, built
// from four 18x18 partial products, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_div6 (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [34:0] dividend,
    output logic signed [31:0]      quotient,
    output logic                    done
);

    localparam int X_W    = 35;
    localparam int PART_W = 18;
    localparam int ACC_W  = 70;
    // ceil(2^36 / 3): gives exact floor(x / 3) for every x below 2^35
    localparam logic [34:0] RECIP = 35'd22906492246;

    logic [X_W-1:0]     x_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [1:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic signed [36:0] n_ext;
    logic signed [36:0] half;
    logic signed [36:0] biased;
    logic [PART_W-1:0]  op_a;
    logic [PART_W-1:0]  op_b;
    logic [35:0]        prod;
    logic [ACC_W-1:0]   term;
    logic [ACC_W-1:0]   acc_next;
    logic signed [36:0] q_full;

    // halve (floor) and bias to a positive multiple-of-three offset
    always_comb
    begin
        n_ext  = 37'(dividend) + 37'sd3;
        half   = n_ext >>> 1;
        biased = half + 37'sd25769803776;
    end

    // one partial product of x times the reciprocal of three
    always_comb
    begin
        op_a = cnt_reg[1] ? {1'b0, x_reg[34:18]} : x_reg[17:0];
        op_b = cnt_reg[0] ? {1'b0, RECIP[34:18]} : RECIP[17:0];
        prod = 36'(op_a) * 36'(op_b);
        if (cnt_reg == 2'd0)
            term = {34'd0, prod};
        else if (cnt_reg == 2'd3)
            term = {prod[33:0], 36'd0};
        else
            term = {16'd0, prod, 18'd0};
        acc_next = acc_reg + term;
    end

    // remove the bias and saturate
    always_comb
    begin
        q_full = $signed({3'b000, acc_reg[69:36]}) - 37'sd8589934592;
        if (q_full > 37'sd2147483647)
            quotient = 32'sh7fffffff;
        else if (q_full < -37'sd2147483648)
            quotient = 32'sh80000000;
        else
            quotient = q_full[31:0];
    end

    assign done = done_reg;

    // accumulate the partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= biased[34:0];
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/pie_lane.sv
// ----------------------------------------------------------------------------
// pie_lane
// One axis of the integrator: slot stores and a sequenced multiply datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pie_lane (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pie_pkg::lane_cmd_t    cmd,
    input  wire logic signed [31:0]    vec,
    input  wire logic [31:0]           inv_mass,
    input  wire logic [16:0]           damping,
    output logic signed [31:0]         pos0,
    output logic signed [31:0]         vel0,
    output logic                       done
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABS_M,
        ST_ABS_W,
        ST_DIV_V,
        ST_WAIT_V,
        ST_DIV_A,
        ST_WAIT_A,
        ST_M1,
        ST_W1,
        ST_M2,
        ST_W2,
        ST_DMP_M,
        ST_DMP_W
    } state_t;

    state_t                    state_reg;
    pie_pkg::func_t            func_reg;
    logic [1:0]                q_reg;
    logic [1:0]                s_reg;
    logic [30:0]               t_reg;
    logic signed [31:0]        pos_reg [pie_pkg::STAGES];
    logic signed [31:0]        vel_reg [pie_pkg::STAGES];
    logic signed [31:0]        acc_reg [pie_pkg::STAGES];
    logic signed [31:0]        frc_reg [pie_pkg::STAGES];
    logic signed [31:0]        vtmp_reg;
    logic signed [31:0]        mv_reg;
    logic signed [31:0]        ma_reg;
    logic signed [65:0]        mul_reg;
    logic                      done_reg;

    logic signed [31:0]        mul_a;
    logic [31:0]               mul_b;
    logic signed [32:0]        mul_bs;
    logic signed [31:0]        rnd;
    logic signed [34:0]        wv;
    logic signed [34:0]        wa;
    logic                      div_start;
    logic signed [34:0]        div_w;
    logic signed [31:0]        div_q;
    logic                      div_done;

    assign pos0 = pos_reg[0];
    assign vel0 = vel_reg[0];
    assign done = done_reg;

    // weighted sums for the combine
    assign wv = 35'(vel_reg[0]) + (35'(vel_reg[1]) <<< 1) + (35'(vel_reg[2]) <<< 1)
              + 35'(vel_reg[3]);
    assign wa = 35'(acc_reg[0]) + (35'(acc_reg[1]) <<< 1) + (35'(acc_reg[2]) <<< 1)
              + 35'(acc_reg[3]);

    assign div_start = (state_reg == ST_DIV_V) || (state_reg == ST_DIV_A);
    assign div_w     = (state_reg == ST_DIV_V) ? wv : wa;

    pie_div6 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_w),
        .quotient (div_q),
        .done     (div_done)
    );

    // select multiplier operands
    always_comb
    begin
        mul_a = vtmp_reg;
        mul_b = {1'b0, t_reg};
        case (state_reg)
            ST_ABS_M:
            begin
                mul_a = frc_reg[q_reg];
                mul_b = inv_mass;
            end
            ST_M1:
            begin
                case (func_reg)
                    pie_pkg::FN_SEMI:    mul_a = acc_reg[q_reg];
                    pie_pkg::FN_COMBINE: mul_a = mv_reg;
                    default:             mul_a = vel_reg[q_reg];
                endcase
            end
            ST_M2:
            begin
                case (func_reg)
                    pie_pkg::FN_SEMI:    mul_a = vtmp_reg;
                    pie_pkg::FN_COMBINE: mul_a = ma_reg;
                    default:             mul_a = acc_reg[q_reg];
                endcase
            end
            ST_DMP_M:
            begin
                mul_a = vtmp_reg;
                mul_b = 32'(damping);
            end
            default:
            begin
                mul_a = vtmp_reg;
            end
        endcase
    end

    assign mul_bs = $signed({1'b0, mul_b});
    assign rnd    = pie_pkg::fix_round(mul_reg);

    // sequence one item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            func_reg  <= pie_pkg::FN_FORCE;
            q_reg     <= '0;
            s_reg     <= '0;
            t_reg     <= '0;
            done_reg  <= 1'b0;
            vtmp_reg  <= '0;
            mv_reg    <= '0;
            ma_reg    <= '0;
            mul_reg   <= '0;
            for (int k = 0; k < pie_pkg::STAGES; k++)
            begin
                pos_reg[k] <= '0;
                vel_reg[k] <= '0;
                acc_reg[k] <= '0;
                frc_reg[k] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            mul_reg  <= 66'(mul_a) * 66'(mul_bs);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.start)
                    begin
                        func_reg <= cmd.func;
                        t_reg    <= cmd.t;
                        q_reg    <= cmd.slot;
                        s_reg    <= cmd.slot;
                        case (cmd.func)
                            pie_pkg::FN_FORCE:
                            begin
                                frc_reg[cmd.slot] <= pie_pkg::sat_add(frc_reg[cmd.slot], vec);
                                done_reg <= 1'b1;
                            end
                            pie_pkg::FN_CLEAR:
                            begin
                                for (int k = 0; k < pie_pkg::STAGES; k++)
                                begin
                                    acc_reg[k] <= '0;
                                    frc_reg[k] <= '0;
                                end
                                done_reg <= 1'b1;
                            end
                            pie_pkg::FN_LOAD_POS:
                            begin
                                pos_reg[0] <= vec;
                                done_reg   <= 1'b1;
                            end
                            pie_pkg::FN_LOAD_VEL:
                            begin
                                vel_reg[0] <= vec;
                                done_reg   <= 1'b1;
                            end
                            pie_pkg::FN_STAGE:
                            begin
                                // stage zero leaves everything as it is
                                if (cmd.slot == 2'd0)
                                    done_reg <= 1'b1;
                                else
                                begin
                                    q_reg     <= cmd.slot - 2'd1;
                                    state_reg <= ST_ABS_M;
                                end
                            end
                            pie_pkg::FN_COMBINE:
                            begin
                                q_reg     <= 2'd3;
                                s_reg     <= 2'd0;
                                state_reg <= ST_ABS_M;
                            end
                            default:
                            begin
                                state_reg <= ST_ABS_M;
                            end
                        endcase
                    end
                end
                ST_ABS_M:
                begin
                    state_reg <= ST_ABS_W;
                end
                ST_ABS_W:
                begin
                    acc_reg[q_reg] <= pie_pkg::sat_add(acc_reg[q_reg], rnd);
                    state_reg <= (func_reg == pie_pkg::FN_COMBINE) ? ST_DIV_V : ST_M1;
                end
                ST_DIV_V:
                begin
                    state_reg <= ST_WAIT_V;
                end
                ST_WAIT_V:
                begin
                    if (div_done)
                    begin
                        mv_reg    <= div_q;
                        state_reg <= ST_DIV_A;
                    end
                end
                ST_DIV_A:
                begin
                    state_reg <= ST_WAIT_A;
                end
                ST_WAIT_A:
                begin
                    if (div_done)
                    begin
                        ma_reg    <= div_q;
                        state_reg <= ST_M1;
                    end
                end
                ST_M1:
                begin
                    state_reg <= ST_W1;
                end
                ST_W1:
                begin
                    case (func_reg)
                        pie_pkg::FN_SEMI:
                            vtmp_reg <= pie_pkg::sat_add(vel_reg[q_reg], rnd);
                        pie_pkg::FN_EXPLICIT:
                            pos_reg[s_reg] <= pie_pkg::sat_add(pos_reg[s_reg], rnd);
                        default:
                            pos_reg[s_reg] <= pie_pkg::sat_add(pos_reg[0], rnd);
                    endcase
                    state_reg <= ST_M2;
                end
                ST_M2:
                begin
                    state_reg <= ST_W2;
                end
                ST_W2:
                begin
                    state_reg <= ST_DMP_M;
                    case (func_reg)
                        pie_pkg::FN_EXPLICIT:
                            vtmp_reg <= pie_pkg::sat_add(vel_reg[q_reg], rnd);
                        pie_pkg::FN_SEMI:
                            pos_reg[s_reg] <= pie_pkg::sat_add(pos_reg[s_reg], rnd);
                        pie_pkg::FN_STAGE:
                        begin
                            vel_reg[s_reg] <= pie_pkg::sat_add(vel_reg[0], rnd);
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        default:
                            vtmp_reg <= pie_pkg::sat_add(vel_reg[0], rnd);
                    endcase
                end
                ST_DMP_M:
                begin
                    state_reg <= ST_DMP_W;
                end
                ST_DMP_W:
                begin
                    vel_reg[s_reg] <= rnd;
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/particle_integrator_euler_rk4_core.sv
// ----------------------------------------------------------------------------
// particle_integrator_euler_rk4_core
// Q16.16 Euler and RK4 integrator for one particle in three dimensions.
// ----------------------------------------------------------------------------
// Three axis lanes run each item in lockstep, each with one 32x33 multiplier
// and a divide-by-six unit built on an 18x18 multiplier; the result register
// merges the slot 0 position and velocity of all three lanes. Force add,
// clear, loads and RK4 stage zero present their result through the lane done
// register and then the output register; explicit and semi-implicit Euler
// steps and RK4 stages run a chain of rounded multiplies through the single
// lane multiplier; the RK4 combine adds two passes through the divide-by-six
// unit (a load and four partial products each). One item is in work at a
// time; a transfer can come in the cycle a result is presented, and a new
// item is taken while the previous result waits in the output register.
`default_nettype none
`include "particle_integrator_euler_rk4_core_macros.svh"

module particle_integrator_euler_rk4_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         func,
    input  wire logic [1:0]         stage,
    input  wire logic [30:0]        time_step,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z,
    output logic signed [31:0]      vel_x,
    output logic signed [31:0]      vel_y,
    output logic signed [31:0]      vel_z,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data
);

    logic [31:0]        inv_mass_reg;
    logic [16:0]        damping_reg;
    logic               busy_reg;
    logic               pend_reg;
    logic               out_valid_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg, vel_z_reg;

    pie_pkg::lane_cmd_t cmd;
    logic               start;
    logic               done_x, done_y, done_z;
    logic               all_done;
    logic               load_out;
    logic signed [31:0] p0_x, p0_y, p0_z, v0_x, v0_y, v0_z;

    assign in_ready  = !busy_reg && !pend_reg;
    assign cfg_ready = 1'b1;
    assign start     = in_valid && in_ready;
    assign all_done  = done_x && done_y && done_z;

    assign cmd.start = start;
    assign cmd.func  = pie_pkg::func_t'(func);
    assign cmd.slot  = stage;
    assign cmd.t     = time_step;

    pie_lane u_lane_x (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .vec(vec_x),
        .inv_mass(inv_mass_reg), .damping(damping_reg),
        .pos0(p0_x), .vel0(v0_x), .done(done_x)
    );

    pie_lane u_lane_y (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .vec(vec_y),
        .inv_mass(inv_mass_reg), .damping(damping_reg),
        .pos0(p0_y), .vel0(v0_y), .done(done_y)
    );

    pie_lane u_lane_z (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .vec(vec_z),
        .inv_mass(inv_mass_reg), .damping(damping_reg),
        .pos0(p0_z), .vel0(v0_z), .done(done_z)
    );

    // merge lane results when the output register is free
    assign load_out = (all_done || pend_reg) && (!out_valid_reg || out_ready);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg <= pie_pkg::INV_MASS_RST;
            damping_reg  <= pie_pkg::DAMPING_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pie_pkg::CFG_INV_MASS: inv_mass_reg <= cfg_data;
                pie_pkg::CFG_DAMPING:  damping_reg  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // track the item in work and the output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
                busy_reg <= 1'b1;
            else if (all_done)
                busy_reg <= 1'b0;

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else
            begin
                if (all_done)
                    pend_reg <= 1'b1;
                if (out_valid_reg && out_ready)
                    out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            pos_x_reg <= p0_x;
            pos_y_reg <= p0_y;
            pos_z_reg <= p0_z;
            vel_x_reg <= v0_x;
            vel_y_reg <= v0_y;
            vel_z_reg <= v0_z;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign vel_x     = vel_x_reg;
    assign vel_y     = vel_y_reg;
    assign vel_z     = vel_z_reg;

    // checks
    `PIE_ASSERT_NXT(a_accept_busy, in_valid && in_ready, busy_reg)
    `PIE_ASSERT_IMP(a_pend_full, pend_reg, out_valid_reg)
    `PIE_ASSERT_IMP(a_pend_idle, pend_reg, !busy_reg)
    `PIE_ASSERT_IMP(a_lockstep, done_x || done_y || done_z, all_done && busy_reg)

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Particle integrator testbench
// Drives force, Euler, RK4 and load operations through the valid/ready input
// channel, predicts slot 0 position and velocity with a Q16.16 model of the
// integrator, and checks every result field in order. Registers change only
// while the core is idle, over several inverse-mass and damping settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import pie_pkg::*;

    typedef struct packed {
        func_t       fn;
        logic [1:0]  slot;
        logic [30:0] t;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } op_t;

    typedef struct packed {
        logic [31:0] px, py, pz, vx, vy, vz;
    } state_out_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [2:0] func;
    logic [1:0] stage;
    logic [30:0] time_step;
    logic signed [31:0] vec_x, vec_y, vec_z;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic cfg_valid, cfg_ready, cfg_index;
    logic [31:0] cfg_data;

    particle_integrator_euler_rk4_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .stage(stage), .time_step(time_step),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [31:0] m_pos [12];
    logic signed [31:0] m_vel [12];
    logic signed [31:0] m_acc [12];
    logic signed [31:0] m_frc [12];
    logic [31:0] m_inv_mass;
    logic [16:0] m_damping;

    op_t        pending_ops[$];
    state_out_t expected_states[$];
    int mismatches = 0;
    int results_seen = 0;
    int ops_sent = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;

    // accepted_last marks a transfer at the previous rising edge
    logic accepted_last;

    function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic [32:0] b);
        logic signed [66:0] p;
        p = 67'(a) * $signed({34'd0, b});
        p = (p + 67'sd32768) >>> 16;
        if (p > 67'sd2147483647) return 32'sh7fffffff;
        if (p < -67'sd2147483648) return 32'sh80000000;
        return p[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return clamp(64'(a) + 64'(b));
    endfunction

    // round half up of w/6, floor division
    function automatic logic signed [31:0] sixth(input logic signed [63:0] w);
        logic signed [63:0] n, q;
        n = w + 3;
        q = n / 6;
        if ((n % 6) != 0 && n < 0) q = q - 1;
        return clamp(q);
    endfunction

    task automatic absorb_force(input int s);
        for (int a = 0; a < 3; a++)
            m_acc[s*3+a] = qadd(m_acc[s*3+a], qmul(m_frc[s*3+a], {1'b0, m_inv_mass}));
    endtask

    task automatic integrate_op(input op_t op);
        logic signed [31:0] v[3];
        logic signed [63:0] wv, wa;
        int s, k, p;
        state_out_t r;
        v[0] = op.vx; v[1] = op.vy; v[2] = op.vz;
        s = op.slot;
        case (op.fn)
            FN_FORCE:
                for (int a = 0; a < 3; a++) m_frc[s*3+a] = qadd(m_frc[s*3+a], v[a]);
            FN_EXPLICIT: begin
                absorb_force(s);
                for (int a = 0; a < 3; a++) begin
                    k = s*3+a;
                    m_pos[k] = qadd(m_pos[k], qmul(m_vel[k], {2'b0, op.t}));
                    m_vel[k] = qadd(m_vel[k], qmul(m_acc[k], {2'b0, op.t}));
                    m_vel[k] = qmul(m_vel[k], {16'b0, m_damping});
                end
            end
            FN_SEMI: begin
                absorb_force(s);
                for (int a = 0; a < 3; a++) begin
                    k = s*3+a;
                    m_vel[k] = qadd(m_vel[k], qmul(m_acc[k], {2'b0, op.t}));
                    m_pos[k] = qadd(m_pos[k], qmul(m_vel[k], {2'b0, op.t}));
                    m_vel[k] = qmul(m_vel[k], {16'b0, m_damping});
                end
            end
            FN_STAGE:
                if (s != 0) begin
                    p = s - 1;
                    absorb_force(p);
                    for (int a = 0; a < 3; a++) begin
                        m_pos[s*3+a] = qadd(m_pos[a], qmul(m_vel[p*3+a], {2'b0, op.t}));
                        m_vel[s*3+a] = qadd(m_vel[a], qmul(m_acc[p*3+a], {2'b0, op.t}));
                    end
                end
            FN_COMBINE: begin
                absorb_force(3);
                for (int a = 0; a < 3; a++) begin
                    wv = 64'(m_vel[a]) + 2*64'(m_vel[3+a]) + 2*64'(m_vel[6+a])
                       + 64'(m_vel[9+a]);
                    wa = 64'(m_acc[a]) + 2*64'(m_acc[3+a]) + 2*64'(m_acc[6+a])
                       + 64'(m_acc[9+a]);
                    m_pos[a] = qadd(m_pos[a], qmul(sixth(wv), {2'b0, op.t}));
                    m_vel[a] = qadd(m_vel[a], qmul(sixth(wa), {2'b0, op.t}));
                    m_vel[a] = qmul(m_vel[a], {16'b0, m_damping});
                end
            end
            FN_CLEAR:
                for (int i = 0; i < 12; i++) begin
                    m_acc[i] = 0;
                    m_frc[i] = 0;
                end
            FN_LOAD_POS:
                for (int a = 0; a < 3; a++) m_pos[a] = v[a];
            default:
                for (int a = 0; a < 3; a++) m_vel[a] = v[a];
        endcase
        r = '{m_pos[0], m_pos[1], m_pos[2], m_vel[0], m_vel[1], m_vel[2]};
        expected_states.push_back(r);
    endtask

    // mostly small Q16.16 values, sometimes full range or extremes
    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'h00100000)) - 32'sh00080000);
        endcase
    endfunction

    function automatic op_t rand_op(input func_t fn, input int s);
        op_t op;
        op.fn = fn;
        op.slot = 2'(s);
        op.t = ($urandom_range(0, 15) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32768));
        op.vx = rand_val();
        op.vy = rand_val();
        op.vz = rand_val();
        return op;
    endfunction

    // one RK4 pass: forces, four stages, combine
    task automatic queue_rk4_pass();
        logic [30:0] t;
        op_t op;
        t = 31'($urandom_range(0, 65536));
        for (int s = 0; s < 4; s++)
            if ($urandom_range(0, 1)) pending_ops.push_back(rand_op(FN_FORCE, s));
        for (int s = 0; s < 4; s++) begin
            op = rand_op(FN_STAGE, s);
            op.t = t;
            pending_ops.push_back(op);
        end
        op = rand_op(FN_COMBINE, $urandom_range(0, 3));
        op.t = t;
        pending_ops.push_back(op);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_INV_MASS) m_inv_mass = data;
        else m_damping = data[16:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || expected_states.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input driver: bursts with random gaps
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                // valid and ready are both high: a transfer is pending; nothing is done here
            end
            if (!in_valid || accepted_last) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    func      <= pending_ops[0].fn;
                    stage     <= pending_ops[0].slot;
                    time_step <= pending_ops[0].t;
                    vec_x     <= pending_ops[0].vx;
                    vec_y     <= pending_ops[0].vy;
                    vec_z     <= pending_ops[0].vz;
                    in_valid  <= 1'b1;
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
            // receiver stall pattern
            stall_phase <= stall_phase + 1;
            out_ready <= (stall_phase[7:6] == 2'b11) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) accepted_last <= 1'b0;
        else accepted_last <= in_valid && in_ready;
    end

    // predictor advance on input transfer
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            integrate_op(pending_ops.pop_front());
            ops_sent <= ops_sent + 1;
        end
    end

    // result monitor
    always @(posedge clk) begin
        state_out_t exp_r;
        state_out_t got;
        if (rst_n && out_valid && out_ready) begin
            got = '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z};
            results_seen <= results_seen + 1;
            if (expected_states.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result %h", got);
            end else begin
                exp_r = expected_states.pop_front();
                if (exp_r !== got) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %h got %h", exp_r, got);
                end
            end
        end
    end

    // stimulus and phases
    initial begin
        logic [31:0] inv_masses[4];
        logic [16:0] dampings[4];
        inv_masses = '{32'd65536, 32'd0, 32'hffffffff, 32'd20000};
        dampings   = '{17'd64881, 17'd65536, 17'd0, 17'h1ffff};
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_INV_MASS;
        cfg_data = '0;
        func = FN_FORCE;
        stage = '0;
        time_step = '0;
        vec_x = '0;
        vec_y = '0;
        vec_z = '0;
        for (int i = 0; i < 12; i++) begin
            m_pos[i] = 0; m_vel[i] = 0; m_acc[i] = 0; m_frc[i] = 0;
        end
        m_inv_mass = INV_MASS_RST;
        m_damping = DAMPING_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every operation, extremes, stage zero, ignored fields
        pending_ops.push_back('{FN_LOAD_POS, 2'd3, 31'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h10000});
        pending_ops.push_back('{FN_LOAD_VEL, 2'd2, 31'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffff0000});
        pending_ops.push_back('{FN_EXPLICIT, 2'd0, 31'h7fffffff, 32'h0, 32'h0, 32'h0});
        pending_ops.push_back('{FN_FORCE, 2'd0, 31'd0, 32'h7fffffff, 32'h80000000, 32'h20000});
        pending_ops.push_back('{FN_FORCE, 2'd0, 31'd0, 32'h7fffffff, 32'h80000000, 32'h20000});
        pending_ops.push_back('{FN_SEMI, 2'd0, 31'h10000, 32'hffffffff, 32'h0, 32'h0});
        pending_ops.push_back('{FN_STAGE, 2'd0, 31'h7fffffff, 32'h0, 32'h0, 32'h0});
        pending_ops.push_back('{FN_STAGE, 2'd1, 31'h8000, 32'h0, 32'h0, 32'h0});
        pending_ops.push_back('{FN_STAGE, 2'd2, 31'h8000, 32'h0, 32'h0, 32'h0});
        pending_ops.push_back('{FN_STAGE, 2'd3, 31'h10000, 32'h0, 32'h0, 32'h0});
        pending_ops.push_back('{FN_COMBINE, 2'd1, 31'h10000, 32'h0, 32'h0, 32'h0});
        pending_ops.push_back('{FN_CLEAR, 2'd3, 31'h7fffffff, 32'hffffffff, 32'h0, 32'h0});
        pending_ops.push_back('{FN_FORCE, 2'd3, 31'd0, 32'h80000000, 32'h80000000, 32'h80000000});
        pending_ops.push_back('{FN_FORCE, 2'd3, 31'd0, 32'h80000000, 32'h1, 32'h7fffffff});
        pending_ops.push_back('{FN_EXPLICIT, 2'd3, 31'h7fffffff, 32'h0, 32'h0, 32'h0});
        pending_ops.push_back('{FN_COMBINE, 2'd0, 31'h7fffffff, 32'h0, 32'h0, 32'h0});
        pending_ops.push_back('{FN_LOAD_POS, 2'd0, 31'd0, 32'h0, 32'h0, 32'h0});
        pending_ops.push_back('{FN_LOAD_VEL, 2'd1, 31'd0, 32'h10000, 32'hfffe0000, 32'h8000});
        pending_ops.push_back('{FN_CLEAR, 2'd0, 31'd0, 32'h0, 32'h0, 32'h0});
        drain();

        // random phases across register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_INV_MASS, ph < 4 ? inv_masses[ph] : $urandom_range(0, 200000));
            write_reg(CFG_DAMPING, ph < 4 ? 32'(dampings[ph]) : $urandom_range(50000, 70000));
            while (ops_sent < 19 + (ph + 1) * 250) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: queue_rk4_pass();
                    4: pending_ops.push_back(rand_op(FN_EXPLICIT, $urandom_range(0, 3)));
                    5: pending_ops.push_back(rand_op(FN_SEMI, $urandom_range(0, 3)));
                    6: pending_ops.push_back(rand_op(FN_FORCE, $urandom_range(0, 3)));
                    7: pending_ops.push_back(rand_op(func_t'($urandom_range(5, 7)),
                                                     $urandom_range(0, 3)));
                    default: pending_ops.push_back(rand_op(func_t'($urandom_range(0, 7)),
                                                           $urandom_range(0, 3)));
                endcase
                while (pending_ops.size() > 8) @(posedge clk);
            end
            drain();
        end

        $display("covered %0d operations and %0d results over 8 register settings",
                 ops_sent, results_seen);
        if (mismatches == 0 && expected_states.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // timeout
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

### particle_integrator_euler_rk4_core.f
+incdir+sv
sv/pie_pkg.sv
sv/pie_div6.sv
sv/pie_lane.sv
sv/particle_integrator_euler_rk4_core.sv
tb/testbench.sv
